// ===== src/scalar_to_color_lut_interpolator_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the scalar-to-color LUT interpolator
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SCALAR_TO_COLOR_LUT_INTERPOLATOR_TOP_DEFINES_SVH
`define SCALAR_TO_COLOR_LUT_INTERPOLATOR_TOP_DEFINES_SVH

// same-cycle implication
`define SLCL_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLCL_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/slcl_pkg.sv =====
// ---------------------------------------------------------------------------
// slcl_pkg
// Types, widths and codes shared by the scalar-to-color LUT interpolator.
// ---------------------------------------------------------------------------
package slcl_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int VAL_W       = 32;
    localparam int FRAC_W      = 16;
    localparam int CHAN_W      = 16;
    localparam int ENTRY_W     = 3 * CHAN_W;
    localparam int EU_W        = 9;
    localparam int P_W         = VAL_W + ADDR_W;
    localparam int Q_W         = ADDR_W + FRAC_W;
    localparam int DCNT_W      = $clog2(Q_W + 1);

    localparam logic signed [VAL_W:0]  ONE_Q16   = (VAL_W + 1)'(65536);
    localparam logic [FRAC_W:0]        FRAC_ONE  = (FRAC_W + 1)'(1) << FRAC_W;

    localparam logic signed [VAL_W-1:0] RANGE_LOW_RST    = 32'sd0;
    localparam logic signed [VAL_W-1:0] RANGE_HIGH_RST   = 32'sd65536;
    localparam logic [EU_W-1:0]         ENTRIES_USED_RST = 9'd256;

    typedef enum logic
    {
        CMD_WRITE = 1'b0,
        CMD_MAP   = 1'b1
    } cmd_t;

    typedef enum logic
    {
        STATUS_OK        = 1'b0,
        STATUS_BAD_INDEX = 1'b1
    } status_t;

    typedef enum logic [1:0]
    {
        REG_RANGE_LOW    = 2'd0,
        REG_RANGE_HIGH   = 2'd1,
        REG_ENTRIES_USED = 2'd2
    } reg_idx_t;

    typedef struct packed
    {
        logic                     command;
        logic [7:0]               entry_index;
        logic [CHAN_W-1:0]        red_in;
        logic [CHAN_W-1:0]        green_in;
        logic [CHAN_W-1:0]        blue_in;
        logic signed [VAL_W-1:0]  scalar;
    } item_t;

    typedef struct packed
    {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic              status;
    } result_t;

    typedef struct packed
    {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

endpackage

// ===== src/slcl_tbl.sv =====
// ---------------------------------------------------------------------------
// slcl_tbl
// Color table: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module slcl_tbl
    import slcl_pkg::*;
(
    input  logic               clk,
    input  logic               we,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [ENTRY_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [ENTRY_W-1:0] rd_data
);

    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/slcl_div.sv =====
// ---------------------------------------------------------------------------
// slcl_div
// Radix-2 restoring divider, one quotient bit per cycle.
// Quotient is floor((dividend << FRAC_W) / divisor), Q_W bits wide.
// ---------------------------------------------------------------------------
module slcl_div
    import slcl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [P_W-1:0]   dividend,
    input  logic [VAL_W-1:0] divisor,
    output logic [Q_W-1:0]   quotient,
    output logic             done
);

    logic [VAL_W-1:0]  rem_reg,  rem_next;
    logic [Q_W-1:0]    sh_reg,   sh_next;
    logic [VAL_W-1:0]  dvs_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic [VAL_W:0]    trial;

    // dividend bits not yet consumed sit at the top of sh_reg, quotient fills from the bottom
    always_comb
    begin
        trial = {rem_reg, sh_reg[Q_W-1]} - {1'b0, dvs_reg};
        if (trial[VAL_W])
        begin
            rem_next = {rem_reg[VAL_W-2:0], sh_reg[Q_W-1]};
            sh_next  = {sh_reg[Q_W-2:0], 1'b0};
        end
        else
        begin
            rem_next = trial[VAL_W-1:0];
            sh_next  = {sh_reg[Q_W-2:0], 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (load)
            begin
                run_reg <= 1'b1;
                cnt_reg <= DCNT_W'(Q_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - DCNT_W'(1);
                if (cnt_reg == DCNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            // quotient fits Q_W bits, so the top VAL_W dividend bits are below the divisor
            rem_reg <= dividend[P_W-1:ADDR_W];
            sh_reg  <= {dividend[ADDR_W-1:0], FRAC_W'(0)};
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            sh_reg  <= sh_next;
        end
    end

    assign quotient = sh_reg;
    assign done     = done_reg;

endmodule

// ===== src/scalar_to_color_lut_interpolator_top.sv =====
// ---------------------------------------------------------------------------
// scalar_to_color_lut_interpolator_top
// Color table with linear interpolation between neighboring entries.
// ---------------------------------------------------------------------------
// A write command's result beat appears on the cycle after start, and busy
// stays low. A map command runs from start to the done beat through a
// 24-step radix-2 divider that splits the scaled position into entry index
// and fraction (skipped when only one entry is in use, since no divide is
// needed then), plus two reads through the table's one read port and one
// shared multiplier stepping through the three channels.
// busy is high while a map is in flight; results are shown on result for one
// cycle with done and cannot be held off.
module scalar_to_color_lut_interpolator_top
    import slcl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  item_t             item,
    output logic              done,
    output result_t           result,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_addr,
    input  logic [VAL_W-1:0]  cfg_wdata
);

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_RANGE,
        S_CLAMP,
        S_MUL,
        S_DIV,
        S_RDA,
        S_RDB,
        S_CAPB,
        S_MULB,
        S_ADDB
    } state_t;

    state_t                   state_reg;
    logic                     busy_reg;
    logic                     done_reg;
    result_t                  result_reg;

    logic signed [VAL_W-1:0]  range_low_reg;
    logic signed [VAL_W-1:0]  range_high_reg;
    logic [EU_W-1:0]          entries_used_reg;

    logic signed [VAL_W-1:0]  scalar_reg;
    logic signed [VAL_W:0]    hi_eff_reg;
    logic signed [VAL_W:0]    vlo_reg;
    logic [VAL_W-1:0]         span_reg;
    logic [VAL_W-1:0]         d_reg;
    logic [ADDR_W-1:0]        idx_reg;
    logic [FRAC_W:0]          frac_reg;
    logic                     single_reg;
    rgb_t                     a_reg;
    rgb_t                     b_reg;
    logic [1:0]               ch_reg;
    logic [CHAN_W-1:0]        prod_reg;

    logic [CNT_W-1:0]         n;
    logic [ADDR_W-1:0]        nm1;
    logic                     accept;
    logic                     wr_fail;
    logic                     tbl_we;
    logic [ADDR_W-1:0]        rd_addr;
    logic [ENTRY_W-1:0]       rd_data;

    logic signed [VAL_W:0]    lo_x;
    logic signed [VAL_W:0]    hi_x;
    logic signed [VAL_W:0]    scalar_x;
    logic signed [VAL_W:0]    vc;
    logic signed [VAL_W:0]    span_x;
    logic signed [VAL_W:0]    d_x;

    logic                     div_load;
    logic [P_W-1:0]           div_dividend;
    logic [Q_W-1:0]           quot;
    logic                     div_done;
    logic [ADDR_W-1:0]        q_int;

    logic [CHAN_W-1:0]        a_ch;
    logic [CHAN_W-1:0]        b_ch;
    logic signed [CHAN_W:0]   diff;
    logic signed [CHAN_W+FRAC_W+1:0] prod_full;
    logic [CHAN_W-1:0]        blend;

    // entries in use: zero reads as one, saturate at the table depth
    always_comb
    begin
        if (entries_used_reg == '0)
        begin
            n = CNT_W'(1);
        end
        else if (32'(entries_used_reg) > 32'(TABLE_DEPTH))
        begin
            n = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            n = CNT_W'(entries_used_reg);
        end
    end

    assign nm1     = ADDR_W'(n - CNT_W'(1));
    assign accept  = start && !busy_reg;
    assign wr_fail = 32'(item.entry_index) >= 32'(n);
    assign tbl_we  = accept && (item.command == CMD_WRITE) && !wr_fail;
    assign rd_addr = (state_reg == S_RDB) ? idx_reg + ADDR_W'(1) : idx_reg;

    assign lo_x     = {range_low_reg[VAL_W-1], range_low_reg};
    assign hi_x     = {range_high_reg[VAL_W-1], range_high_reg};
    assign scalar_x = {scalar_reg[VAL_W-1], scalar_reg};
    assign vc       = (vlo_reg > hi_eff_reg) ? hi_eff_reg : vlo_reg;
    assign span_x   = hi_eff_reg - lo_x;
    assign d_x      = vc - lo_x;

    assign div_load     = (state_reg == S_MUL);
    assign div_dividend = {ADDR_W'(0), d_reg} * {VAL_W'(0), nm1};
    assign q_int        = quot[Q_W-1:FRAC_W];

    always_comb
    begin
        unique case (ch_reg)
            2'd0:
            begin
                a_ch = a_reg.red;
                b_ch = b_reg.red;
            end
            2'd1:
            begin
                a_ch = a_reg.green;
                b_ch = b_reg.green;
            end
            default:
            begin
                a_ch = a_reg.blue;
                b_ch = b_reg.blue;
            end
        endcase
    end

    // a + floor((b - a) * frac / 2^16); only the low 16 bits matter for the sum
    assign diff      = $signed({1'b0, b_ch}) - $signed({1'b0, a_ch});
    assign prod_full = diff * $signed({1'b0, frac_reg});
    assign blend     = a_ch + prod_reg;

    slcl_tbl u_tbl
    (
        .clk     (clk),
        .we      (tbl_we),
        .wr_addr (ADDR_W'(item.entry_index)),
        .wr_data ({item.red_in, item.green_in, item.blue_in}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    slcl_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .dividend (div_dividend),
        .divisor  (span_reg),
        .quotient (quot),
        .done     (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg    <= RANGE_LOW_RST;
            range_high_reg   <= RANGE_HIGH_RST;
            entries_used_reg <= ENTRIES_USED_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_RANGE_LOW:    range_low_reg    <= cfg_wdata;
                REG_RANGE_HIGH:   range_high_reg   <= cfg_wdata;
                REG_ENTRIES_USED: entries_used_reg <= cfg_wdata[EU_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            ch_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (item.command == CMD_WRITE)
                        begin
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            busy_reg <= 1'b1;
                            state_reg <= (n == CNT_W'(1)) ? S_RDA : S_RANGE;
                        end
                    end
                end
                S_RANGE:  state_reg <= S_CLAMP;
                S_CLAMP:  state_reg <= S_MUL;
                S_MUL:    state_reg <= S_DIV;
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_RDA;
                    end
                end
                S_RDA:    state_reg <= S_RDB;
                S_RDB:    state_reg <= S_CAPB;
                S_CAPB:
                begin
                    ch_reg    <= '0;
                    state_reg <= S_MULB;
                end
                S_MULB:   state_reg <= S_ADDB;
                S_ADDB:
                begin
                    ch_reg <= ch_reg + 2'd1;
                    if (ch_reg == 2'd2)
                    begin
                        state_reg <= S_IDLE;
                        busy_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_MULB;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    scalar_reg <= item.scalar;
                    idx_reg    <= '0;
                    frac_reg   <= '0;
                    single_reg <= (n == CNT_W'(1));
                    if (item.command == CMD_WRITE)
                    begin
                        result_reg.red_out   <= '0;
                        result_reg.green_out <= '0;
                        result_reg.blue_out  <= '0;
                        result_reg.status    <= wr_fail ? STATUS_BAD_INDEX : STATUS_OK;
                    end
                    else
                    begin
                        result_reg.status <= STATUS_OK;
                    end
                end
            end
            S_RANGE:
            begin
                hi_eff_reg <= (hi_x <= lo_x) ? lo_x + ONE_Q16 : hi_x;
                vlo_reg    <= (scalar_x < lo_x) ? lo_x : scalar_x;
            end
            S_CLAMP:
            begin
                span_reg <= span_x[VAL_W-1:0];
                d_reg    <= d_x[VAL_W-1:0];
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    // only the very top of the range lands on the last entry
                    if (q_int == nm1)
                    begin
                        idx_reg  <= nm1 - ADDR_W'(1);
                        frac_reg <= FRAC_ONE;
                    end
                    else
                    begin
                        idx_reg  <= q_int;
                        frac_reg <= {1'b0, quot[FRAC_W-1:0]};
                    end
                end
            end
            S_RDB:
            begin
                a_reg <= rgb_t'(rd_data);
            end
            S_CAPB:
            begin
                b_reg <= single_reg ? a_reg : rgb_t'(rd_data);
            end
            S_MULB:
            begin
                prod_reg <= prod_full[CHAN_W+FRAC_W-1:FRAC_W];
            end
            S_ADDB:
            begin
                unique case (ch_reg)
                    2'd0:    result_reg.red_out   <= blend;
                    2'd1:    result_reg.green_out <= blend;
                    default: result_reg.blue_out  <= blend;
                endcase
            end
            default: ;
        endcase
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== src/slcl_checker.sv =====
// ---------------------------------------------------------------------------
// slcl_checker
// Port-level checks on the scalar-to-color LUT interpolator.
// ---------------------------------------------------------------------------
`include "scalar_to_color_lut_interpolator_top_defines.svh"

module slcl_checker
    import slcl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  item_t   item,
    input  logic    done,
    input  result_t result
);

    // a refused write carries no color
    `SLCL_ASSERT_IMP(a_status_no_color, done && result.status, result.red_out == '0 && result.green_out == '0 && result.blue_out == '0, "refused write beat carries color")

    // a write answers on the very next cycle
    `SLCL_ASSERT_NXT(a_write_one_cycle, start && !busy && item.command == CMD_WRITE, done, "write beat not delivered next cycle")

    // a map goes busy and never answers on the next cycle
    `SLCL_ASSERT_NXT(a_map_busy, start && !busy && item.command == CMD_MAP, busy && !done, "map did not raise busy")

    // the done beat of a write or a map comes with busy released
    `SLCL_ASSERT_IMP(a_done_not_busy, done, !busy, "done beat while busy")

endmodule

bind scalar_to_color_lut_interpolator_top slcl_checker u_slcl_checker (.*);
